// ----- design/tde_pkg.sv -----
// ----------------------------------------------------------------------------
// tde_pkg
// Shared types and constants of the tile delta encoder.
// ----------------------------------------------------------------------------
package tde_pkg;

  // field widths fixed by the interface
  localparam int PIX_W     = 24;
  localparam int LANES     = 8;
  localparam int IDX_W     = 11;
  localparam int FW_W      = 10;
  localparam int FH_W      = 9;
  localparam int CFG_IDX_W = 1;

  // opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  // configuration reset values
  localparam logic [FW_W-1:0] FW_RESET = 10'd640;
  localparam logic [FH_W-1:0] FH_RESET = 9'd480;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDR,
    S_READ,
    S_CMP,
    S_DIV,
    S_FIX,
    S_IDX,
    S_TRD,
    S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;    // take the input word
    logic calc;      // form the reference address
    logic rd_ref;    // read the reference entry
    logic commit;    // compare, write back, advance position
    logic div;       // tile column count, first step
    logic fix;       // tile column count, correction
    logic idx;       // tile index
    logic tile_rd;   // read one half row of the tile buffer
    logic next;      // result taken, advance half row
    logic finish;    // tile over: clear buffer, advance tile
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic tile_done;
    logic emit;
    logic last;
  } sts_t;

endpackage

// ----- design/tde_ram.sv -----
// ----------------------------------------------------------------------------
// tde_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tde_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 160
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tde_ctrl.sv -----
// ----------------------------------------------------------------------------
// tde_ctrl
// Sequencer of the tile delta encoder: pixel steps and tile emission.
// ----------------------------------------------------------------------------
module tde_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  tde_pkg::sts_t  sts_i,
  output tde_pkg::cmd_t  cmd_o
);
  import tde_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (!sts_i.is_clear) state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.calc = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.rd_ref = 1'b1;
        state_d      = S_CMP;
      end
      S_CMP: begin
        cmd_o.commit = 1'b1;
        if (sts_i.emit) begin
          state_d = S_DIV;
        end else begin
          cmd_o.finish = sts_i.tile_done;
          state_d      = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = S_FIX;
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_IDX;
      end
      S_IDX: begin
        cmd_o.idx = 1'b1;
        state_d   = S_TRD;
      end
      S_TRD: begin
        cmd_o.tile_rd = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.last) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end else begin
            cmd_o.next = 1'b1;
            state_d    = S_TRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- design/tde_dp.sv -----
// ----------------------------------------------------------------------------
// tde_dp
// Datapath: configuration, tile position, reference frame, tile buffer.
// ----------------------------------------------------------------------------
module tde_dp #(
  parameter int MAX_WIDTH   = 640,
  parameter int MAX_HEIGHT  = 480,
  parameter int TILE_WIDTH  = 16,
  parameter int TILE_HEIGHT = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tde_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tde_pkg::FW_W-1:0]          cfg_data_i,
  input  logic                              opcode_i,
  input  logic [tde_pkg::PIX_W-1:0]         pixel_rgb_i,
  input  logic                              starts_frame_i,
  input  logic                              key_req_i,
  input  tde_pkg::cmd_t                     cmd_i,
  output tde_pkg::sts_t                     sts_o,
  output logic [tde_pkg::IDX_W-1:0]         tile_index_o,
  output logic                              keyframe_o,
  output logic [tde_pkg::LANES*tde_pkg::PIX_W-1:0] pixels_o,
  output logic                              last_of_tile_o,
  output logic                              frame_done_o
);
  import tde_pkg::*;

  localparam int HR      = (TILE_WIDTH + LANES - 1) / LANES;
  localparam int RESULTS = TILE_HEIGHT * HR;
  localparam int TAW     = $clog2(RESULTS);
  localparam int WB      = $clog2(MAX_WIDTH + 1);
  localparam int HB      = $clog2(MAX_HEIGHT + 1);
  localparam int XTW     = $clog2(TILE_WIDTH + 1);
  localparam int YTW     = $clog2(TILE_HEIGHT + 1);
  localparam int CW      = $clog2(MAX_WIDTH / TILE_WIDTH + 2);
  localparam int RW      = $clog2(MAX_HEIGHT / TILE_HEIGHT + 2);
  localparam int XW      = $clog2(MAX_WIDTH + 2 * TILE_WIDTH + 1);
  localparam int YW      = $clog2(MAX_HEIGHT + 2 * TILE_HEIGHT + 1);
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int PW      = YW + WB;
  localparam int NW      = $clog2(MAX_WIDTH + TILE_WIDTH);
  localparam int DIVS    = 20;
  localparam int RECIP   = (1 << DIVS) / TILE_WIDTH;
  localparam int RCW     = DIVS + 1;
  localparam int QW      = NW + RCW;
  localparam int WORD_W  = LANES * PIX_W;

  // configuration
  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;
  logic [WB-1:0]   eff_w;
  logic [HB-1:0]   eff_h;

  // reference bookkeeping
  logic          ref_valid_q;
  logic [WB-1:0] ref_w_q;
  logic [HB-1:0] ref_h_q;
  logic          key_q;

  // position
  logic [CW-1:0]  col_q;
  logic [RW-1:0]  row_q;
  logic [XTW-1:0] x_q;
  logic [YTW-1:0] y_q;
  logic [XW-1:0]  sx, next_col_x;
  logic [YW-1:0]  sy, next_row_y;

  // pixel in flight
  logic [PIX_W-1:0] pix_q;
  logic             inr_q;
  logic [AW-1:0]    ref_addr_q;
  logic [PW-1:0]    prod;
  logic [PIX_W-1:0] ref_rdata;

  // tile assembly and buffer
  logic [LANES-1:0][PIX_W-1:0] asm_q, asm_now;
  logic [RESULTS-1:0]          wvalid_q;
  logic                        changed_q, changed_now;
  logic [2:0]                  lane;
  logic                        row_end, flush, tile_done;
  logic [TAW-1:0]              waddr;
  logic [WORD_W-1:0]           tile_rdata;

  // emission
  logic [TAW-1:0]    k_q;
  logic              rdv_q;
  logic              fd_q;
  logic [NW-1:0]     div_n;
  logic [QW-1:0]     qm_q;
  logic [CW-1:0]     q_est;
  logic [CW-1:0]     cols_q;
  logic [NW+1:0]     q_chk;
  logic [RW+CW:0]    idx_full;
  logic [IDX_W-1:0]  index_q;

  // effective frame size
  always_comb begin
    if (fw_q == '0) eff_w = WB'(1);
    else if (32'(fw_q) > 32'(MAX_WIDTH)) eff_w = WB'(MAX_WIDTH);
    else eff_w = WB'(fw_q);
    if (fh_q == '0) eff_h = HB'(1);
    else if (32'(fh_q) > 32'(MAX_HEIGHT)) eff_h = HB'(MAX_HEIGHT);
    else eff_h = HB'(fh_q);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_RESET;
      fh_q <= FH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  fw_q <= cfg_data_i;
        CFG_HEIGHT: fh_q <= cfg_data_i[FH_W-1:0];
        default:    ;
      endcase
    end
  end

  // frame coordinates of the current position
  assign sx         = XW'(col_q) * XW'(TILE_WIDTH) + XW'(x_q);
  assign sy         = YW'(row_q) * YW'(TILE_HEIGHT) + YW'(y_q);
  assign next_col_x = (XW'(col_q) + XW'(1)) * XW'(TILE_WIDTH);
  assign next_row_y = (YW'(row_q) + YW'(1)) * YW'(TILE_HEIGHT);
  assign prod       = PW'(sy) * PW'(eff_w);

  // step decisions
  assign lane        = 3'(x_q);
  assign row_end     = (XTW'(x_q + XTW'(1)) >= XTW'(TILE_WIDTH))
                       || (XW'(sx + XW'(1)) >= XW'(eff_w));
  assign tile_done   = row_end && ((YTW'(y_q + YTW'(1)) >= YTW'(TILE_HEIGHT))
                       || (YW'(sy + YW'(1)) >= YW'(eff_h)));
  assign flush       = (lane == 3'd7) || row_end;
  assign changed_now = changed_q || (inr_q && (ref_rdata != pix_q));
  assign waddr       = TAW'(y_q) * TAW'(HR) + TAW'(x_q >> 3);

  always_comb begin
    asm_now       = asm_q;
    asm_now[lane] = pix_q;
  end

  assign sts_o.is_clear  = (opcode_i == OP_CLEAR);
  assign sts_o.tile_done = tile_done;
  assign sts_o.emit      = tile_done && (changed_now || key_q);
  assign sts_o.last      = (k_q == TAW'(RESULTS - 1));

  // control state: reference, position, tile flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_valid_q <= 1'b0;
      ref_w_q     <= '0;
      ref_h_q     <= '0;
      key_q       <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      changed_q   <= 1'b0;
      wvalid_q    <= '0;
      k_q         <= '0;
    end else begin
      // accepted word
      if (cmd_i.accept) begin
        if (opcode_i == OP_CLEAR) begin
          ref_valid_q <= 1'b0;
          ref_w_q     <= '0;
          ref_h_q     <= '0;
        end else if (starts_frame_i) begin
          if (key_req_i || !ref_valid_q || ref_w_q != eff_w || ref_h_q != eff_h) begin
            key_q       <= 1'b1;
            ref_valid_q <= 1'b1;
            ref_w_q     <= eff_w;
            ref_h_q     <= eff_h;
          end else begin
            key_q <= 1'b0;
          end
          col_q     <= '0;
          row_q     <= '0;
          x_q       <= '0;
          y_q       <= '0;
          changed_q <= 1'b0;
          wvalid_q  <= '0;
        end
      end
      // pixel commit and position advance, tile flags left to the tile end
      if (cmd_i.commit) begin
        if (!cmd_i.finish) begin
          changed_q <= changed_now;
          if (flush) wvalid_q[waddr] <= 1'b1;
        end
        if (row_end) begin
          x_q <= '0;
          if (tile_done) y_q <= '0;
          else y_q <= YTW'(y_q + YTW'(1));
        end else begin
          x_q <= XTW'(x_q + XTW'(1));
        end
      end
      // half row counter
      if (cmd_i.next) k_q <= TAW'(k_q + TAW'(1));
      // tile over
      if (cmd_i.finish) begin
        changed_q <= 1'b0;
        wvalid_q  <= '0;
        k_q       <= '0;
        if (next_col_x >= XW'(eff_w)) begin
          col_q <= '0;
          if (next_row_y >= YW'(eff_h)) row_q <= '0;
          else row_q <= RW'(row_q + RW'(1));
        end else begin
          col_q <= CW'(col_q + CW'(1));
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q <= pixel_rgb_i;
      if (starts_frame_i && opcode_i == OP_PIXEL) asm_q <= '0;
    end
    if (cmd_i.calc) begin
      inr_q      <= (sx < XW'(eff_w)) && (sy < YW'(eff_h));
      ref_addr_q <= AW'(prod + PW'(sx));
    end
    if (cmd_i.commit) begin
      if (flush) asm_q <= '0;
      else asm_q <= asm_now;
      if (tile_done) begin
        fd_q <= (next_col_x >= XW'(eff_w)) && (next_row_y >= YW'(eff_h));
      end
    end
    if (cmd_i.div) qm_q <= QW'(div_n) * QW'(RECIP);
    if (cmd_i.fix) begin
      if (q_chk <= (NW+2)'(div_n)) cols_q <= CW'(q_est + CW'(1));
      else cols_q <= q_est;
    end
    if (cmd_i.idx) index_q <= IDX_W'(idx_full);
    if (cmd_i.tile_rd) rdv_q <= wvalid_q[k_q];
  end

  // tile column count by reciprocal multiply with one correction
  assign div_n    = NW'(eff_w) + NW'(TILE_WIDTH - 1);
  assign q_est    = CW'(qm_q >> DIVS);
  assign q_chk    = (NW+2)'((NW+2)'(q_est) + (NW+2)'(1)) * (NW+2)'(TILE_WIDTH);
  assign idx_full = (RW+CW+1)'(row_q) * (RW+CW+1)'(cols_q) + (RW+CW+1)'(col_q);

  // reference frame store
  tde_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && inr_q),
    .waddr_i (ref_addr_q),
    .wdata_i (pix_q),
    .re_i    (cmd_i.rd_ref),
    .raddr_i (ref_addr_q),
    .rdata_o (ref_rdata)
  );

  // tile buffer, one half row a word
  tde_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RESULTS)
  ) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && flush),
    .waddr_i (waddr),
    .wdata_i (asm_now),
    .re_i    (cmd_i.tile_rd),
    .raddr_i (k_q),
    .rdata_o (tile_rdata)
  );

  // result word
  assign tile_index_o   = index_q;
  assign keyframe_o     = key_q;
  assign pixels_o       = rdv_q ? tile_rdata : '0;
  assign last_of_tile_o = sts_o.last;
  assign frame_done_o   = sts_o.last && fd_q;

endmodule

// ----- design/tile_delta_encoder.sv -----
// ----------------------------------------------------------------------------
// tile_delta_encoder
// Tile based frame difference encoder: compares pixels with a stored reference
// frame; emits changed or keyframe tiles as half rows of eight pixels.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  input     in         in_valid/in_ready   opcode, pixel_rgb, starts_frame,
//                                           key_req
//  output    out        out_valid/out_ready tile_index, keyframe, pixel_0..7,
//                                           last_of_tile, frame_done
//  config    in         cfg_we              cfg_index, cfg_data
//
//  A pixel word goes through address multiply, reference read, and compare and
//  write back. A clear word is taken in the idle state. An emitted tile first
//  forms its index (column count, correction, index), then reads and offers
//  its half rows (20 by default) one by one, each held until taken.
//  Reset clears position and reference flags and loads the 640 by 480
//  configuration; the reference frame memory is not cleared.
// ----------------------------------------------------------------------------
module tile_delta_encoder #(
  parameter int MAX_WIDTH   = 640,
  parameter int MAX_HEIGHT  = 480,
  parameter int TILE_WIDTH  = 16,
  parameter int TILE_HEIGHT = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tde_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tde_pkg::FW_W-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [tde_pkg::PIX_W-1:0]     pixel_rgb_i,
  input  logic                          starts_frame_i,
  input  logic                          key_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tde_pkg::IDX_W-1:0]     tile_index_o,
  output logic                          keyframe_o,
  output logic [tde_pkg::PIX_W-1:0]     pixel_0_o,
  output logic [tde_pkg::PIX_W-1:0]     pixel_1_o,
  output logic [tde_pkg::PIX_W-1:0]     pixel_2_o,
  output logic [tde_pkg::PIX_W-1:0]     pixel_3_o,
  output logic [tde_pkg::PIX_W-1:0]     pixel_4_o,
  output logic [tde_pkg::PIX_W-1:0]     pixel_5_o,
  output logic [tde_pkg::PIX_W-1:0]     pixel_6_o,
  output logic [tde_pkg::PIX_W-1:0]     pixel_7_o,
  output logic                          last_of_tile_o,
  output logic                          frame_done_o
);
  import tde_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [LANES*PIX_W-1:0] pixels;

  // sequencer
  tde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  tde_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .TILE_WIDTH  (TILE_WIDTH),
    .TILE_HEIGHT (TILE_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .pixel_rgb_i    (pixel_rgb_i),
    .starts_frame_i (starts_frame_i),
    .key_req_i      (key_req_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .tile_index_o   (tile_index_o),
    .keyframe_o     (keyframe_o),
    .pixels_o       (pixels),
    .last_of_tile_o (last_of_tile_o),
    .frame_done_o   (frame_done_o)
  );

  // lane split of the result word
  assign pixel_0_o = pixels[0*PIX_W +: PIX_W];
  assign pixel_1_o = pixels[1*PIX_W +: PIX_W];
  assign pixel_2_o = pixels[2*PIX_W +: PIX_W];
  assign pixel_3_o = pixels[3*PIX_W +: PIX_W];
  assign pixel_4_o = pixels[4*PIX_W +: PIX_W];
  assign pixel_5_o = pixels[5*PIX_W +: PIX_W];
  assign pixel_6_o = pixels[6*PIX_W +: PIX_W];
  assign pixel_7_o = pixels[7*PIX_W +: PIX_W];

endmodule

// ----- sim/tb_tile_delta_encoder.sv -----
// ----------------------------------------------------------------------------
// tb_tile_delta_encoder
// Self-checking testbench of the tile delta encoder. A scoreboard class
// tracks the reference frame, tile position and tile buffer, predicts every
// emitted half row word, and compares it field by field with the block.
// ----------------------------------------------------------------------------
module tb_tile_delta_encoder;
  import tde_pkg::*;

  localparam int TW      = 16;
  localparam int TH      = 10;
  localparam int MAXW    = 640;
  localparam int MAXH    = 480;
  localparam int MAXPIX  = MAXW * MAXH;
  localparam int WORDS_PER_TILE = TH * 2;
  localparam int ITEMS   = 310;

  // one emitted half row
  typedef struct {
    logic [IDX_W-1:0] tile_index;
    logic             keyframe;
    logic [PIX_W-1:0] pix [LANES];
    logic             last_of_tile;
    logic             frame_done;
  } tile_word_t;

  // predicts emitted tiles and checks the block's output words
  class tile_scoreboard;
    logic [PIX_W-1:0] ref_mem [MAXPIX];
    bit               ref_written [MAXPIX];
    bit               ref_valid;
    int unsigned      ref_w, ref_h;
    logic [PIX_W-1:0] tile_buf [TW*TH];
    bit               tile_chg;
    bit               frame_key;
    int unsigned      tcol, trow, xt, yt;
    logic [FW_W-1:0]  frame_w;
    logic [FH_W-1:0]  frame_h;
    tile_word_t       expected_words [$];
    int               errors;

    function new();
      ref_valid = 0; ref_w = 0; ref_h = 0;
      tile_chg = 0; frame_key = 0;
      tcol = 0; trow = 0; xt = 0; yt = 0;
      frame_w = FW_RESET; frame_h = FH_RESET;
      errors = 0;
      foreach (tile_buf[i]) tile_buf[i] = '0;
    endfunction

    function int unsigned eff_w();
      if (frame_w == 0) return 1;
      if (frame_w > MAXW) return MAXW;
      return frame_w;
    endfunction

    function int unsigned eff_h();
      if (frame_h == 0) return 1;
      if (frame_h > MAXH) return MAXH;
      return frame_h;
    endfunction

    function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [FW_W-1:0] data);
      if (idx == CFG_WIDTH) frame_w = data;
      else frame_h = data[FH_W-1:0];
    endfunction

    // a frame start without a key request would compare against never written entries
    function bit needs_key();
      int unsigned n;
      n = eff_w() * eff_h();
      if (!ref_valid || ref_w != eff_w() || ref_h != eff_h()) return 0;
      for (int unsigned i = 0; i < n; i++)
        if (!ref_written[i]) return 1;
      return 0;
    endfunction

    // stored reference value at the position the next pixel lands on
    function logic [PIX_W-1:0] next_ref(bit first);
      int unsigned sx, sy;
      sx = first ? 0 : tcol * TW + xt;
      sy = first ? 0 : trow * TH + yt;
      if (sx < eff_w() && sy < eff_h() && ref_written[sy*eff_w()+sx])
        return ref_mem[sy*eff_w()+sx];
      return '0;
    endfunction

    function void clear_tile();
      foreach (tile_buf[i]) tile_buf[i] = '0;
      tile_chg = 0;
    endfunction

    function void note_input(logic op, logic [PIX_W-1:0] pix, logic sf, logic fk);
      int unsigned w, h, sx, sy, cols, idx;
      bit tile_done, fdone;
      tile_word_t tw;
      w = eff_w(); h = eff_h();
      tile_done = 0; fdone = 0;
      if (op == OP_CLEAR) begin
        ref_valid = 0; ref_w = 0; ref_h = 0;
        return;
      end
      if (sf) begin
        frame_key = fk || !ref_valid || ref_w != w || ref_h != h;
        if (frame_key) begin
          ref_valid = 1; ref_w = w; ref_h = h;
        end
        tcol = 0; trow = 0; xt = 0; yt = 0;
        clear_tile();
      end
      sx = tcol * TW + xt;
      sy = trow * TH + yt;
      if (xt < TW && yt < TH) tile_buf[yt*TW + xt] = pix;
      if (sx < w && sy < h) begin
        idx = sy * w + sx;
        if (ref_mem[idx] !== pix) tile_chg = 1;
        ref_mem[idx] = pix;
        ref_written[idx] = 1;
      end
      // advance position, clipping at the frame edge
      xt++;
      if (xt >= TW || sx + 1 >= w) begin
        xt = 0;
        yt++;
        if (yt >= TH || sy + 1 >= h) begin
          yt = 0;
          tile_done = 1;
        end
      end
      if (!tile_done) return;
      fdone = ((tcol + 1) * TW >= w) && ((trow + 1) * TH >= h);
      if (tile_chg || frame_key) begin
        cols = (w + TW - 1) / TW;
        for (int k = 0; k < WORDS_PER_TILE; k++) begin
          tw.tile_index = IDX_W'(trow * cols + tcol);
          tw.keyframe = frame_key;
          for (int j = 0; j < LANES; j++)
            tw.pix[j] = tile_buf[(k/2)*TW + (k%2)*8 + j];
          tw.last_of_tile = (k == WORDS_PER_TILE - 1);
          tw.frame_done = fdone && (k == WORDS_PER_TILE - 1);
          expected_words.push_back(tw);
        end
      end
      clear_tile();
      if ((tcol + 1) * TW >= w) begin
        tcol = 0;
        trow++;
        if (trow * TH >= h) trow = 0;
      end else begin
        tcol++;
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] exp);
      $display("mismatch %s: got %0h expected %0h", what, got, exp);
      errors++;
    endtask

    task check(tile_word_t got);
      tile_word_t e;
      if (expected_words.size() == 0) begin
        report("unexpected word, tile_index", 32'(got.tile_index), 0);
        return;
      end
      e = expected_words.pop_front();
      if (got.tile_index !== e.tile_index)
        report("tile_index", 32'(got.tile_index), 32'(e.tile_index));
      if (got.keyframe !== e.keyframe)
        report("keyframe", 32'(got.keyframe), 32'(e.keyframe));
      for (int j = 0; j < LANES; j++)
        if (got.pix[j] !== e.pix[j])
          report($sformatf("pixel_%0d", j), 32'(got.pix[j]), 32'(e.pix[j]));
      if (got.last_of_tile !== e.last_of_tile)
        report("last_of_tile", 32'(got.last_of_tile), 32'(e.last_of_tile));
      if (got.frame_done !== e.frame_done)
        report("frame_done", 32'(got.frame_done), 32'(e.frame_done));
    endtask
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
  logic [FW_W-1:0]   cfg_data = '0;
  logic              in_valid = 0;
  logic              in_ready_o;
  logic              opcode = OP_PIXEL;
  logic [PIX_W-1:0]  pixel_rgb = '0;
  logic              starts_frame = 0;
  logic              key_req = 0;
  logic              out_valid_o;
  logic              out_ready = 0;
  logic [IDX_W-1:0]  tile_index_o;
  logic              keyframe_o;
  logic [PIX_W-1:0]  pixel_o [LANES];
  logic              last_of_tile_o;
  logic              frame_done_o;

  tile_scoreboard sb;
  bit idle_on   = 1;
  bit hold_req  = 0;
  int hold_cnt  = 0;
  int stall_cnt = 0;
  int items_sent = 0;

  tile_delta_encoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode),
    .pixel_rgb_i    (pixel_rgb),
    .starts_frame_i (starts_frame),
    .key_req_i      (key_req),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .tile_index_o   (tile_index_o),
    .keyframe_o     (keyframe_o),
    .pixel_0_o      (pixel_o[0]),
    .pixel_1_o      (pixel_o[1]),
    .pixel_2_o      (pixel_o[2]),
    .pixel_3_o      (pixel_o[3]),
    .pixel_4_o      (pixel_o[4]),
    .pixel_5_o      (pixel_o[5]),
    .pixel_6_o      (pixel_o[6]),
    .pixel_7_o      (pixel_o[7]),
    .last_of_tile_o (last_of_tile_o),
    .frame_done_o   (frame_done_o)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // output side: check accepted words, random stalls and one long hold-off
  always @(posedge clk_i) begin
    tile_word_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        got.tile_index = tile_index_o;
        got.keyframe = keyframe_o;
        for (int j = 0; j < LANES; j++) got.pix[j] = pixel_o[j];
        got.last_of_tile = last_of_tile_o;
        got.frame_done = frame_done_o;
        sb.check(got);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_cnt = 800;
        out_ready <= 0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready <= 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_cnt = $urandom_range(0, 2);
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // offer one word and wait for it to be taken
  task send(logic op, logic [PIX_W-1:0] pix, logic sf, logic fk);
    if (op == OP_PIXEL && sf && !fk && sb.needs_key()) fk = 1;
    in_valid <= 1;
    opcode <= op;
    pixel_rgb <= pix;
    starts_frame <= sf;
    key_req <= fk;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(op, pix, sf, fk);
    items_sent++;
    // no idling in the last part of the run
    if (items_sent >= ITEMS - 50) idle_on = 0;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every expected word has come out
  task drain();
    in_valid <= 0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [FW_W-1:0] data);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 0;
    sb.write_cfg(idx, data);
  endtask

  // send n pixels from a frame start; change_mod picks how often a pixel differs
  task send_frame(int n, bit fk, int change_mod, bit noise);
    logic [PIX_W-1:0] v;
    for (int i = 0; i < n; i++) begin
      if (items_sent >= ITEMS) break;
      if (noise && $urandom_range(0, 39) == 0) send(OP_CLEAR, PIX_W'($urandom), 0, 0);
      if (noise && i > 0 && $urandom_range(0, 69) == 0) break;
      v = sb.next_ref(i == 0);
      if (change_mod == 0 || $urandom_range(0, change_mod - 1) == 0) v = PIX_W'($urandom);
      send(OP_PIXEL, v, i == 0, (i == 0) ? fk : 1'($urandom));
    end
  endtask

  initial begin
    int w, h;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: clear first, then a partial tile at reset geometry
    send(OP_CLEAR, 24'hFFFFFF, 1, 1);
    send_frame(16, 0, 0, 0);
    // width and height of zero act as one: single pixel frames
    write_reg(CFG_WIDTH, '0);
    write_reg(CFG_HEIGHT, '0);
    send(OP_PIXEL, 24'h000000, 1, 0);
    send(OP_PIXEL, 24'h000000, 1, 0);
    send(OP_PIXEL, 24'hFFFFFF, 1, 0);
    send(OP_PIXEL, 24'hFFFFFF, 1, 1);
    send(OP_PIXEL, 24'h123456, 0, 0);
    send(OP_CLEAR, 24'h0, 0, 0);
    send(OP_PIXEL, 24'hFFFFFF, 1, 0);
    // oversize width saturates: a full tile and part of the next on one line
    write_reg(CFG_WIDTH, 10'h3FF);
    write_reg(CFG_HEIGHT, 10'd1);
    send_frame(20, 1, 0, 0);
    // oversize height saturates: tall one pixel wide frame
    write_reg(CFG_WIDTH, 10'd1);
    write_reg(CFG_HEIGHT, 10'h1FF);
    send_frame(12, 0, 0, 0);
    // full sizes, abandoned partial tile then two frames of one exact-width tile
    write_reg(CFG_WIDTH, 10'd640);
    write_reg(CFG_HEIGHT, 10'd480);
    send_frame(10, 0, 0, 0);
    write_reg(CFG_WIDTH, 10'd16);
    write_reg(CFG_HEIGHT, 10'd2);
    send_frame(32, 0, 0, 0);
    send_frame(32, 0, 0, 0);

    // back pressure: receiver holds off while a two tile keyframe streams in
    write_reg(CFG_WIDTH, 10'd24);
    write_reg(CFG_HEIGHT, 10'd2);
    hold_req = 1;
    send_frame(48, 1, 0, 0);

    // random phases of frames, mostly well formed, some noise
    while (items_sent < ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 20);
        h = $urandom_range(1, 12);
        write_reg(CFG_WIDTH, w[FW_W-1:0]);
        write_reg(CFG_HEIGHT, h[FW_W-1:0]);
      end
      repeat ($urandom_range(1, 3)) begin
        send_frame(sb.eff_w() * sb.eff_h(), $urandom_range(0, 4) == 0,
                   ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(8, 60), 1);
        // pixels past the final one wrap into a further frame
        if ($urandom_range(0, 5) == 0 && items_sent < ITEMS)
          repeat ($urandom_range(1, 20))
            send(OP_PIXEL, PIX_W'($urandom), 0, 1'($urandom));
      end
      if ($urandom_range(0, 3) == 0) drain();
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("PASS tile_delta_encoder");
    end else begin
      $display("FAIL tile_delta_encoder");
    end
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("FAIL tile_delta_encoder");
    $finish;
  end

endmodule

// ----- tile_delta_encoder.f -----
design/tde_pkg.sv
design/tde_ram.sv
design/tde_ctrl.sv
design/tde_dp.sv
design/tile_delta_encoder.sv
sim/tb_tile_delta_encoder.sv
